// ===== hw/rtl/urtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urtc_pkg
// shared widths, register map, arithmetic constants and control types for the
// temperature compensated ultrasonic rangefinder
// ----------------------------------------------------------------------------
package urtc_pkg;

   localparam int COUNT_W    = 16;
   localparam int TEMP_W     = 16;
   localparam int TIMEOUT_W  = 16;
   localparam int TRIG_W     = 8;
   localparam int DIST_W     = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_TRIG_HIGH = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_TRIG_LOW  = 2'd2;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd25000;
   localparam logic [TRIG_W-1:0]    TRIG_HIGH_RST = 8'd10;
   localparam logic [TRIG_W-1:0]    TRIG_LOW_RST  = 8'd2;

   // centidegree scale, speed numerator base and reciprocal multipliers
   localparam int TEMP_SCALE   = 17500;
   localparam int SPEED_BASE   = 304300;
   localparam int FULL_SCALE   = 65535;
   localparam int DIV100_MUL   = 671089;
   localparam int DIV100_SHIFT = 26;
   localparam int DIV125_MUL   = 17179870;
   localparam int DIV125_SHIFT = 31;
   localparam int DIV16_SHIFT  = 4;

   localparam int PROD1_W = 31;
   localparam int TEMPQ_W = PROD1_W - 16;
   localparam int NUM_W   = 19;
   localparam int PROD2_W = 39;
   localparam int SPEED_W = 12;
   localparam int PROD3_W = COUNT_W + SPEED_W;
   localparam int Y_W     = PROD3_W - DIV16_SHIFT;
   localparam int PROD4_W = Y_W + 25;
   localparam int QUOT_W  = PROD4_W - DIV125_SHIFT;

   typedef enum logic [1:0] {
      CNT_HOLD  = 2'd0,
      CNT_CLEAR = 2'd1,
      CNT_INC   = 2'd2,
      CNT_ONE   = 2'd3
   } cnt_op_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic [TRIG_W-1:0]    trig_high_ticks;
      logic [TRIG_W-1:0]    trig_low_ticks;
   } cfg_type;

   typedef struct packed {
      cnt_op_type cnt_op;
      logic       latch_temp;
      logic       emit;
      logic       res_trig;
      logic       res_busy;
      logic       res_done;
      logic       res_tmo;
      logic       res_dist;
   } cmd_type;

   typedef struct packed {
      logic low_done;
      logic high_done;
      logic wait_tmo;
      logic low_zero;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/urtc_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urtc_csr
// apb-style register file holding timeout and trigger widths
// ----------------------------------------------------------------------------
module urtc_csr
   import urtc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [REG_IDX_W-1:0]  idx;
   logic                  wr_en;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_TIMEOUT:   cfg_in.timeout_ticks   = pwdata[TIMEOUT_W-1:0];
            REG_TRIG_HIGH: cfg_in.trig_high_ticks = pwdata[TRIG_W-1:0];
            REG_TRIG_LOW:  cfg_in.trig_low_ticks  = pwdata[TRIG_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_TIMEOUT:   prdata = CSR_DATA_W'(cfg_ff.timeout_ticks);
         REG_TRIG_HIGH: prdata = CSR_DATA_W'(cfg_ff.trig_high_ticks);
         REG_TRIG_LOW:  prdata = CSR_DATA_W'(cfg_ff.trig_low_ticks);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks   <= TIMEOUT_RST;
         cfg_ff.trig_high_ticks <= TRIG_HIGH_RST;
         cfg_ff.trig_low_ticks  <= TRIG_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/urtc_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urtc_dp
// tick counter, latched temperature, distance multiply chain and result
// word register
// ----------------------------------------------------------------------------
module urtc_dp
   import urtc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire cmd_type           cmd,
   output status_type             stat,
   input  wire logic [TEMP_W-1:0] req_raw_temp,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_trig_level,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic                   rsp_timed_out,
   output logic      [DIST_W-1:0] rsp_distance_centi_cm
);

   logic [COUNT_W-1:0] tick_count_ff, tick_count_in;
   logic [TEMP_W-1:0]  held_temp_ff, held_temp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               trig_ff, busy_ff, done_ff, tmo_ff;
   logic [DIST_W-1:0]  dist_ff;

   logic [COUNT_W:0]   cnt_plus;
   logic               out_free;

   logic [PROD1_W-1:0] prod1_ff, prod1_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [PROD2_W-1:0] prod2_ff, prod2_in;
   logic [PROD3_W-1:0] prod3_ff, prod3_in;
   logic [PROD4_W-1:0] prod4_ff, prod4_in;
   logic [TEMPQ_W-1:0] temp_hi;
   logic [TEMPQ_W-1:0] temp_q;
   logic [16:0]        temp_sum;
   logic [SPEED_W-1:0] speed10;
   logic [QUOT_W-1:0]  quot;
   logic [DIST_W-1:0]  dist_sat;

   assign cnt_plus = {1'b0, tick_count_ff} + (COUNT_W+1)'(1);
   assign out_free = ~rsp_valid_ff | rsp_ready;

   assign stat.low_done  = cnt_plus >= (COUNT_W+1)'(cfg.trig_low_ticks);
   assign stat.high_done = cnt_plus >= (COUNT_W+1)'(cfg.trig_high_ticks);
   assign stat.wait_tmo  = (tick_count_ff == {COUNT_W{1'b1}})
                         | (tick_count_ff >= COUNT_W'(cfg.timeout_ticks));
   assign stat.low_zero  = cfg.trig_low_ticks == '0;
   assign stat.out_free  = out_free;

   always_comb begin
      unique case (cmd.cnt_op)
         CNT_HOLD:  tick_count_in = tick_count_ff;
         CNT_CLEAR: tick_count_in = '0;
         CNT_INC:   tick_count_in = cnt_plus[COUNT_W-1:0];
         CNT_ONE:   tick_count_in = COUNT_W'(1);
         default:   tick_count_in = tick_count_ff;
      endcase
   end

   assign held_temp_in = cmd.latch_temp ? req_raw_temp : held_temp_ff;

   // temp_q = 17500 * held / 65535, speed10 = (304300 + 6 * temp_q) / 100
   assign prod1_in = PROD1_W'(held_temp_ff) * PROD1_W'(TEMP_SCALE);
   assign temp_hi  = prod1_ff[PROD1_W-1:16];
   assign temp_sum = 17'(temp_hi) + 17'(prod1_ff[15:0]);
   assign temp_q   = temp_hi + TEMPQ_W'(temp_sum >= 17'(FULL_SCALE));
   assign num_in   = NUM_W'(SPEED_BASE) + (NUM_W'(temp_q) << 2) + (NUM_W'(temp_q) << 1);
   assign prod2_in = PROD2_W'(num_ff) * PROD2_W'(DIV100_MUL);
   assign speed10  = prod2_ff[DIV100_SHIFT +: SPEED_W];

   // distance = pulse * speed10 / 16 / 125
   assign prod3_in = PROD3_W'(tick_count_ff) * PROD3_W'(speed10);
   assign prod4_in = PROD4_W'(prod3_ff[PROD3_W-1:DIV16_SHIFT]) * PROD4_W'(DIV125_MUL);
   assign quot     = prod4_ff[PROD4_W-1:DIV125_SHIFT];
   assign dist_sat = (|quot[QUOT_W-1:DIST_W]) ? {DIST_W{1'b1}} : quot[DIST_W-1:0];

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         held_temp_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_count_ff <= tick_count_in;
         held_temp_ff  <= held_temp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      num_ff   <= num_in;
      prod2_ff <= prod2_in;
      prod3_ff <= prod3_in;
      prod4_ff <= prod4_in;
      if (cmd.emit) begin
         trig_ff <= cmd.res_trig;
         busy_ff <= cmd.res_busy;
         done_ff <= cmd.res_done;
         tmo_ff  <= cmd.res_tmo;
         dist_ff <= cmd.res_dist ? dist_sat : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trig_level        = trig_ff;
   assign rsp_busy_res          = busy_ff;
   assign rsp_done_res          = done_ff;
   assign rsp_timed_out         = tmo_ff;
   assign rsp_distance_centi_cm = dist_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/urtc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urtc_ctrl
// measurement phase sequencer: trigger low/high, echo rise wait, echo high
// count and the distance calculation steps
// ----------------------------------------------------------------------------
module urtc_ctrl
   import urtc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_start_req,
   input  wire logic       req_echo_level,
   input  wire status_type stat,
   output cmd_type         cmd
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_TLOW   = 11'b000_0000_0010,
      ST_THIGH  = 11'b000_0000_0100,
      ST_RISE   = 11'b000_0000_1000,
      ST_HIGH   = 11'b000_0001_0000,
      ST_CALC_1 = 11'b000_0010_0000,
      ST_CALC_2 = 11'b000_0100_0000,
      ST_CALC_3 = 11'b000_1000_0000,
      ST_CALC_4 = 11'b001_0000_0000,
      ST_CALC_5 = 11'b010_0000_0000,
      ST_OUTPUT = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      in_tick;
   logic      accept;

   assign in_tick   = (state_ff == ST_IDLE) || (state_ff == ST_TLOW)
                   || (state_ff == ST_THIGH) || (state_ff == ST_RISE)
                   || (state_ff == ST_HIGH);
   assign req_ready = in_tick & stat.out_free;
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.cnt_op = CNT_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.emit = 1'b1;
               if (req_start_req) begin
                  cmd.res_busy   = 1'b1;
                  cmd.latch_temp = 1'b1;
                  cmd.cnt_op     = CNT_CLEAR;
                  state_in       = stat.low_zero ? ST_THIGH : ST_TLOW;
               end
            end
         end
         ST_TLOW: begin
            if (accept) begin
               cmd.emit     = 1'b1;
               cmd.res_busy = 1'b1;
               if (stat.low_done) begin
                  cmd.cnt_op = CNT_CLEAR;
                  state_in   = ST_THIGH;
               end else begin
                  cmd.cnt_op = CNT_INC;
               end
            end
         end
         ST_THIGH: begin
            if (accept) begin
               cmd.emit     = 1'b1;
               cmd.res_busy = 1'b1;
               cmd.res_trig = 1'b1;
               if (stat.high_done) begin
                  cmd.cnt_op = CNT_CLEAR;
                  state_in   = ST_RISE;
               end else begin
                  cmd.cnt_op = CNT_INC;
               end
            end
         end
         ST_RISE: begin
            if (accept) begin
               cmd.emit = 1'b1;
               if (req_echo_level) begin
                  cmd.res_busy = 1'b1;
                  cmd.cnt_op   = CNT_ONE;
                  state_in     = ST_HIGH;
               end else if (stat.wait_tmo) begin
                  cmd.res_done = 1'b1;
                  cmd.res_tmo  = 1'b1;
                  cmd.cnt_op   = CNT_CLEAR;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.res_busy = 1'b1;
                  cmd.cnt_op   = CNT_INC;
               end
            end
         end
         ST_HIGH: begin
            if (accept) begin
               if (!req_echo_level) begin
                  state_in = ST_CALC_1;
               end else if (stat.wait_tmo) begin
                  cmd.emit     = 1'b1;
                  cmd.res_done = 1'b1;
                  cmd.res_tmo  = 1'b1;
                  cmd.cnt_op   = CNT_CLEAR;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.emit     = 1'b1;
                  cmd.res_busy = 1'b1;
                  cmd.cnt_op   = CNT_INC;
               end
            end
         end
         ST_CALC_1: state_in = ST_CALC_2;
         ST_CALC_2: state_in = ST_CALC_3;
         ST_CALC_3: state_in = ST_CALC_4;
         ST_CALC_4: state_in = ST_CALC_5;
         ST_CALC_5: state_in = ST_OUTPUT;
         ST_OUTPUT: begin
            if (stat.out_free) begin
               cmd.emit     = 1'b1;
               cmd.res_done = 1'b1;
               cmd.res_dist = 1'b1;
               cmd.cnt_op   = CNT_CLEAR;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            cmd.cnt_op = CNT_CLEAR;
            state_in   = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ultrasonic_range_with_temp_comp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_range_with_temp_comp
// one word per microsecond tick: trigger pulse generation, echo timing and
// temperature compensated distance in hundredths of a cm
// ----------------------------------------------------------------------------
// timing: a result word is valid the cycle after its input word is taken;
//    the distance word for the tick that ends an echo comes from ST_OUTPUT
// throughput: one word per cycle while the output is free, but req_ready is
//    low after an echo ends, through the five registered arithmetic stages
// reset: synchronous; clears phase, tick counter, latched temperature and
//    output valid, and loads the register defaults
module ultrasonic_range_with_temp_comp
   import urtc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_start_req,
   input  wire logic                  req_echo_level,
   input  wire logic [TEMP_W-1:0]     req_raw_temp,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_trig_level,
   output logic                       rsp_busy_res,
   output logic                       rsp_done_res,
   output logic                       rsp_timed_out,
   output logic      [DIST_W-1:0]     rsp_distance_centi_cm,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type stat;

   urtc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   urtc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_req  (req_start_req),
      .req_echo_level (req_echo_level),
      .stat           (stat),
      .cmd            (cmd)
   );

   urtc_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_raw_temp          (req_raw_temp),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_trig_level        (rsp_trig_level),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_timed_out         (rsp_timed_out),
      .rsp_distance_centi_cm (rsp_distance_centi_cm)
   );

   // no new word while a stalled result word occupies the output
   a_ready_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("req_ready high with output word blocked");

   a_timeout_no_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_timed_out) |-> (rsp_done_res && rsp_distance_centi_cm == '0))
      else $error("timeout word without done or with distance");

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_busy_res && rsp_done_res))
      else $error("busy and done in one word");

   a_trig_in_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trig_level) |-> (rsp_busy_res && !rsp_done_res))
      else $error("trigger high outside a measurement");

endmodule
`default_nettype wire

// ===== dv/ultrasonic_range_with_temp_comp_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_range_with_temp_comp_tb
// self-checking bench for the rangefinder: tick words go in over valid/ready,
// every result word is checked against a cycle-free model of the measurement
// kept in the bench; a directed table covers reset defaults, register extremes
// and timeouts, then random measurements follow under random idling on both
// sides and register readback over the apb port
// ----------------------------------------------------------------------------
module ultrasonic_range_with_temp_comp_tb;
   import urtc_pkg::*;

   localparam int unsigned COUNT_CEIL = (1 << COUNT_W) - 1;
   localparam int ITEM_TARGET    = 1750;
   localparam int MIN_RUNS       = 8;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 12;
   localparam int SHOW_LIMIT     = 10;
   localparam int IDLE_PCT       = 12;

   typedef enum logic [2:0] {
      RNG_IDLE  = 3'd0,
      RNG_TLOW  = 3'd1,
      RNG_THIGH = 3'd2,
      RNG_RISE  = 3'd3,
      RNG_HIGH  = 3'd4
   } range_phase_t;

   typedef struct packed {
      logic              trig;
      logic              busy;
      logic              done;
      logic              tmo;
      logic [DIST_W-1:0] centi_cm;
   } range_word_t;

   typedef struct packed {
      logic                 go;
      logic                 extra_starts;
      logic [TIMEOUT_W-1:0] timeout;
      logic [TRIG_W-1:0]    trig_high;
      logic [TRIG_W-1:0]    trig_low;
      logic [15:0]          junk;
      logic [TEMP_W-1:0]    temp;
      logic [31:0]          rise;
      logic [31:0]          pulse;
      logic                 typed;
      logic                 typed_tmo;
      logic [DIST_W-1:0]    typed_cm;
   } drill_row_t;

   localparam int DRILL_ROWS = 12;
   localparam drill_row_t DRILL [DRILL_ROWS] = '{
      // go  starts timeout  high  low  junk  temp  rise  pulse  typed tmo  cm
      '{1'b0, 1'b0, 16'd25000, 8'd10, 8'd2, 16'h0, 16'hFFFF, 32'd0, 32'd0,
        1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 16'd25000, 8'd10, 8'd2, 16'h0, 16'h0000, 32'd3, 32'd1,
        1'b1, 1'b0, 16'd1},
      '{1'b1, 1'b0, 16'd25000, 8'd10, 8'd2, 16'h0, 16'hFFFF, 32'd0, 32'd20,
        1'b1, 1'b0, 16'd40},
      '{1'b1, 1'b0, 16'd25000, 8'd10, 8'd2, 16'h0, 16'h0000, 32'd5, 32'd20,
        1'b1, 1'b0, 16'd30},
      '{1'b1, 1'b1, 16'd25000, 8'd10, 8'd2, 16'h0, 16'h5A3C, 32'd7, 32'd123,
        1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 16'd1, 8'd1, 8'd0, 16'h0, 16'h8000, 32'd5, 32'd1,
        1'b1, 1'b1, 16'd0},
      '{1'b1, 1'b0, 16'd1, 8'd1, 8'd0, 16'h0, 16'h1234, 32'd0, 32'd5,
        1'b1, 1'b1, 16'd0},
      '{1'b1, 1'b0, 16'd1, 8'd1, 8'd0, 16'h0, 16'h0000, 32'd1, 32'd1,
        1'b1, 1'b0, 16'd1},
      '{1'b1, 1'b1, 16'd3, 8'd0, 8'd255, 16'h0, 16'hC3A5, 32'd0, 32'd3,
        1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 16'd0, 8'd255, 8'd0, 16'h0, 16'h7FFF, 32'd1, 32'd1,
        1'b1, 1'b1, 16'd0},
      '{1'b1, 1'b1, 16'd40, 8'd3, 8'd1, 16'hFFFF, 16'hFFFF, 32'd2, 32'd20,
        1'b0, 1'b0, 16'd0},
      '{1'b1, 1'b0, 16'd65535, 8'd1, 8'd0, 16'h0, 16'hFFFF, 32'd0, 32'd20,
        1'b1, 1'b0, 16'd40}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_start_req;
   logic                  req_echo_level;
   logic [TEMP_W-1:0]     req_raw_temp;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_trig_level;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic                  rsp_timed_out;
   logic [DIST_W-1:0]     rsp_distance_centi_cm;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   range_word_t   expected_words [$];
   range_phase_t  rng_phase;
   int unsigned   rng_count;
   logic [TEMP_W-1:0] rng_temp;
   cfg_type       cfg_now;
   int            fail_count   = 0;
   int            sent_words   = 0;
   int            rx_hold_left = 0;
   bit            steady       = 1'b0;

   ultrasonic_range_with_temp_comp dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void note_mismatch(input string msg);
      fail_count++;
      if (fail_count <= SHOW_LIMIT) begin
         $display("%s", msg);
      end
   endfunction

   function automatic logic [DIST_W-1:0] centi_cm_of(input int unsigned pulse);
      longint raw, temp_centi, speed_x10, span;
      raw = rng_temp;
      // centidegrees, then speed of sound in 0.1 m/s
      temp_centi = (TEMP_SCALE * raw) / FULL_SCALE - 4500;
      speed_x10  = (331300 + 6 * temp_centi) / 100;
      span       = longint'(pulse) * speed_x10 / 2000;
      return (span > 65535) ? 16'hFFFF : DIST_W'(span);
   endfunction

   function automatic bit echo_wait_expired();
      if (rng_count >= COUNT_CEIL) begin
         return 1'b1;
      end
      rng_count++;
      return rng_count > cfg_now.timeout_ticks;
   endfunction

   function automatic range_word_t range_step(input logic start, input logic echo,
                                              input logic [TEMP_W-1:0] temp);
      range_word_t w;
      w = '0;
      case (rng_phase)
         RNG_IDLE: begin
            if (start) begin
               rng_temp  = temp;
               rng_count = 0;
               rng_phase = (cfg_now.trig_low_ticks != 0) ? RNG_TLOW : RNG_THIGH;
               w.busy    = 1'b1;
            end
         end
         RNG_TLOW: begin
            w.busy = 1'b1;
            rng_count++;
            if (rng_count >= cfg_now.trig_low_ticks) begin
               rng_count = 0;
               rng_phase = RNG_THIGH;
            end
         end
         RNG_THIGH: begin
            w.busy = 1'b1;
            w.trig = 1'b1;
            rng_count++;
            if (rng_count >= cfg_now.trig_high_ticks) begin
               rng_count = 0;
               rng_phase = RNG_RISE;
            end
         end
         RNG_RISE: begin
            if (echo) begin
               w.busy    = 1'b1;
               rng_count = 1;
               rng_phase = RNG_HIGH;
            end else if (echo_wait_expired()) begin
               w.done    = 1'b1;
               w.tmo     = 1'b1;
               rng_count = 0;
               rng_phase = RNG_IDLE;
            end else begin
               w.busy = 1'b1;
            end
         end
         RNG_HIGH: begin
            if (!echo) begin
               w.done     = 1'b1;
               w.centi_cm = centi_cm_of(rng_count);
               rng_count  = 0;
               rng_phase  = RNG_IDLE;
            end else if (echo_wait_expired()) begin
               w.done    = 1'b1;
               w.tmo     = 1'b1;
               rng_count = 0;
               rng_phase = RNG_IDLE;
            end else begin
               w.busy = 1'b1;
            end
         end
         default: begin
            rng_phase = RNG_IDLE;
            rng_count = 0;
         end
      endcase
      return w;
   endfunction

   task automatic send_word(input logic start, input logic echo,
                            input logic [TEMP_W-1:0] temp, input logic typed,
                            input logic typed_tmo, input logic [DIST_W-1:0] typed_cm);
      range_word_t w;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_req  <= start;
      req_echo_level <= echo;
      req_raw_temp   <= temp;
      do @(posedge clock); while (!req_ready);
      sent_words++;
      w = range_step(start, echo, temp);
      if (typed && w.done) begin
         w.tmo      = typed_tmo;
         w.centi_cm = typed_cm;
      end
      expected_words.push_back(w);
   endtask

   task automatic run_measurement(input logic [TEMP_W-1:0] temp, input int unsigned rise,
                                  input int unsigned pulse, input logic extra_starts,
                                  input logic glitch, input logic typed,
                                  input logic typed_tmo, input logic [DIST_W-1:0] typed_cm);
      int unsigned rise_left, pulse_left;
      logic start, echo;
      rise_left  = rise;
      pulse_left = pulse;
      send_word(1'b1, 1'($urandom_range(1)), temp, typed, typed_tmo, typed_cm);
      while (rng_phase != RNG_IDLE) begin
         start = extra_starts && ($urandom_range(1) == 1);
         echo  = 1'($urandom_range(1));
         if (rng_phase == RNG_RISE) begin
            if (rise_left != 0) begin
               echo = 1'b0;
               rise_left--;
            end else begin
               echo = 1'b1;
               if (pulse_left != 0) pulse_left--;
            end
         end else if (rng_phase == RNG_HIGH) begin
            echo = (pulse_left != 0);
            if (pulse_left != 0) pulse_left--;
         end
         if (glitch && (rng_phase == RNG_RISE || rng_phase == RNG_HIGH) &&
             $urandom_range(9) == 0) begin
            echo = !echo;
         end
         send_word(start, echo, 16'($urandom), typed, typed_tmo, typed_cm);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value,
                            input logic [CSR_DATA_W-1:0] mask);
      logic [CSR_DATA_W-1:0] kept;
      kept = value & mask;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_TIMEOUT:   cfg_now.timeout_ticks   = kept[TIMEOUT_W-1:0];
         REG_TRIG_HIGH: cfg_now.trig_high_ticks = kept[TRIG_W-1:0];
         REG_TRIG_LOW:  cfg_now.trig_low_ticks  = kept[TRIG_W-1:0];
         default: ;
      endcase
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== kept) begin
         note_mismatch($sformatf("register %0d readback: expected %h, got %h",
                                 idx, kept, prdata));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [TIMEOUT_W-1:0] timeout,
                            input logic [TRIG_W-1:0] trig_high,
                            input logic [TRIG_W-1:0] trig_low, input logic [15:0] junk);
      logic [CSR_DATA_W-1:0] noise;
      noise = {junk, junk};
      write_reg(REG_TIMEOUT, (noise & 32'hFFFF_0000) | {16'b0, timeout}, 32'h0000_FFFF);
      write_reg(REG_TRIG_HIGH, (noise & 32'hFFFF_FF00) | {24'b0, trig_high}, 32'h0000_00FF);
      write_reg(REG_TRIG_LOW, (noise & 32'hFFFF_FF00) | {24'b0, trig_low}, 32'h0000_00FF);
   endtask

   initial begin : result_check
      range_word_t want, got;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_trig_level, rsp_busy_res, rsp_done_res, rsp_timed_out,
                   rsp_distance_centi_cm};
            if (expected_words.size() == 0) begin
               note_mismatch($sformatf("unexpected word: trig=%b busy=%b done=%b tmo=%b cm=%0d",
                                       got.trig, got.busy, got.done, got.tmo, got.centi_cm));
            end else begin
               want = expected_words.pop_front();
               if (got.trig !== want.trig || got.busy !== want.busy ||
                   got.done !== want.done || got.tmo !== want.tmo ||
                   got.centi_cm !== want.centi_cm) begin
                  note_mismatch($sformatf(
                     "expected trig=%b busy=%b done=%b tmo=%b cm=%0d, got %b %b %b %b %0d",
                     want.trig, want.busy, want.done, want.tmo, want.centi_cm,
                     got.trig, got.busy, got.done, got.tmo, got.centi_cm));
               end
            end
         end
         if (rx_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rx_hold_left--;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin : stimulus
      int unsigned k, rise, pulse, reach;
      logic [TEMP_W-1:0]    temp;
      logic [TIMEOUT_W-1:0] timeout;
      logic [TRIG_W-1:0]    trig_high, trig_low;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_start_req  <= 1'b0;
      req_echo_level <= 1'b0;
      req_raw_temp   <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      rng_phase = RNG_IDLE;
      rng_count = 0;
      rng_temp  = '0;
      cfg_now   = '{TIMEOUT_RST, TRIG_HIGH_RST, TRIG_LOW_RST};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DRILL_ROWS; i++) begin
         if (DRILL[i].timeout != cfg_now.timeout_ticks ||
             DRILL[i].trig_high != cfg_now.trig_high_ticks ||
             DRILL[i].trig_low != cfg_now.trig_low_ticks) begin
            drain_results();
            configure(DRILL[i].timeout, DRILL[i].trig_high, DRILL[i].trig_low, DRILL[i].junk);
         end
         if (DRILL[i].go) begin
            run_measurement(DRILL[i].temp, DRILL[i].rise, DRILL[i].pulse,
                            DRILL[i].extra_starts, 1'b0, DRILL[i].typed,
                            DRILL[i].typed_tmo, DRILL[i].typed_cm);
         end else begin
            send_word(1'b0, 1'b1, DRILL[i].temp, 1'b0, 1'b0, '0);
         end
      end

      k = 0;
      while (sent_words < ITEM_TARGET || k < MIN_RUNS) begin
         if (k % 2 == 0) begin
            drain_results();
            case ($urandom_range(5))
               0:       timeout = 16'd1;
               1:       timeout = 16'd65535;
               default: timeout = 16'($urandom_range(2, 80));
            endcase
            case ($urandom_range(5))
               0:       trig_high = 8'd0;
               1:       trig_high = 8'd255;
               default: trig_high = 8'($urandom_range(1, 12));
            endcase
            case ($urandom_range(5))
               0:       trig_low = 8'd0;
               1:       trig_low = 8'd255;
               default: trig_low = 8'($urandom_range(0, 12));
            endcase
            configure(timeout, trig_high, trig_low, 16'($urandom));
         end
         steady = (k >= 3 && k < 6);
         // output side stalls while input keeps coming
         if (k == 1) rx_hold_left = RX_HOLD_CYCLES;
         repeat ($urandom_range(2)) begin
            send_word(1'b0, 1'($urandom_range(1)), 16'($urandom), 1'b0, 1'b0, '0);
         end
         case ($urandom_range(6))
            0:       temp = 16'h0000;
            1:       temp = 16'hFFFF;
            default: temp = 16'($urandom);
         endcase
         reach = (cfg_now.timeout_ticks + 2 > 300) ? 300 : cfg_now.timeout_ticks + 2;
         rise  = ($urandom_range(9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, reach);
         pulse = ($urandom_range(9) < 7) ? $urandom_range(1, 40) : $urandom_range(1, reach);
         run_measurement(temp, rise, pulse, 1'($urandom_range(9) < 4),
                         1'($urandom_range(99) < 15), 1'b0, 1'b0, '0);
         k++;
      end
      steady = 1'b0;

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ultrasonic_range_with_temp_comp: match");
      end else begin
         $display("ultrasonic_range_with_temp_comp: mismatch");
      end
      $finish;
   end

   initial begin : run_limit
      #8_000_000;
      $display("ultrasonic_range_with_temp_comp: mismatch");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/urtc_pkg.sv
hw/rtl/urtc_csr.sv
hw/rtl/urtc_dp.sv
hw/rtl/urtc_ctrl.sv
hw/rtl/ultrasonic_range_with_temp_comp.sv
dv/ultrasonic_range_with_temp_comp_tb.sv
